/* hw/rtl/npt_pkg.sv */
// Shared types and constants of the nested phase memory peak tracker.
// Used by the sequencer, the counter unit and the top level; depends on nothing.
`default_nettype none

package npt_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int COUNT_WIDTH = 48;

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam int OP_W    = 3;
   localparam int ST_W    = 2;
   localparam int OPEN_W  = 5;
   localparam int AMT_W   = 32;
   localparam int TS_W    = 32;
   localparam int FIELD_W = 48;

   localparam int CNT_W = 2 * COUNT_WIDTH;
   localparam int FRM_W = COUNT_WIDTH + TS_W;

   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
   localparam logic [OP_W-1:0] OP_REALLOC = 3'd2;
   localparam logic [OP_W-1:0] OP_BEGIN   = 3'd3;
   localparam logic [OP_W-1:0] OP_END     = 3'd4;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [AMT_W-1:0] amount;
      logic [AMT_W-1:0] old_amount;
      logic [TS_W-1:0]  timestamp;
   } npt_req_type;

   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic               phase_ended;
      logic [OPEN_W-1:0]  open_phases;
      logic [FIELD_W-1:0] phase_offset;
      logic [FIELD_W-1:0] phase_peak;
      logic [FIELD_W-1:0] phase_current;
      logic [TS_W-1:0]    phase_start;
      logic [TS_W-1:0]    phase_end;
   } npt_rsp_type;

   // One stack level as held in the counter memory.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] now;
      logic [COUNT_WIDTH-1:0] peak;
   } npt_cnt_type;

   // One stack level as held in the frame memory.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] offset;
      logic [TS_W-1:0]        start_time;
   } npt_frm_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic              busy;
      logic              cnt_rd_en;
      logic              frm_rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              cnt_wr_en;
      logic              frm_wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_clear;
      logic              sub;
      logic              use_old;
      logic              has_parent;
      logic              rsp_load;
   } npt_ctrl_type;

   // Outcome of the current transaction as the sequencer sees it.
   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic               ended;
      logic [DEPTH_W-1:0] depth;
   } npt_stat_type;

endpackage

`default_nettype wire

/* hw/rtl/npt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependencies.
`default_nettype none

module npt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/npt_alu.sv */
// Shared counter unit: adds to or subtracts from one level's usage and raises its peak.
// Depends on npt_pkg for the counter width.
`default_nettype none

module npt_alu (
   input  wire logic [npt_pkg::COUNT_WIDTH-1:0] now_value,
   input  wire logic [npt_pkg::COUNT_WIDTH-1:0] peak_value,
   input  wire logic [npt_pkg::COUNT_WIDTH-1:0] amount_value,
   input  wire logic                            subtract,
   output logic      [npt_pkg::COUNT_WIDTH-1:0] now_next,
   output logic      [npt_pkg::COUNT_WIDTH-1:0] peak_next
);

   // Usage wraps at the counter width; the peak only moves on an add.
   always_comb begin
      if (subtract) begin
         now_next = now_value - amount_value;
      end else begin
         now_next = now_value + amount_value;
      end
      if (!subtract && (now_next > peak_value)) begin
         peak_next = now_next;
      end else begin
         peak_next = peak_value;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/npt_seq.sv */
// Sequencer of the tracker: decodes a transaction, walks the open levels and tracks depth.
// Depends on npt_pkg for the control and status structs and the codes.
`default_nettype none

module npt_seq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [npt_pkg::OP_W-1:0] operation,
   input  wire logic                     paused,
   input  wire logic                     out_free,
   output npt_pkg::npt_ctrl_type         ctrl,
   output npt_pkg::npt_stat_type         stat
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_PASS     = 6'b000010,
      S_BEGIN_RD = 6'b000100,
      S_BEGIN_WR = 6'b001000,
      S_END_RD   = 6'b010000,
      S_DONE     = 6'b100000
   } seq_state_type;

   seq_state_type                   state_ff, state_in;
   logic [npt_pkg::DEPTH_W-1:0]     depth_ff, depth_in;
   logic [npt_pkg::DEPTH_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                            pv_ff, pv_in;
   logic [npt_pkg::ADDR_W-1:0]      wr_addr_ff, wr_addr_in;
   logic                            sub_ff, sub_in;
   logic                            use_old_ff, use_old_in;
   logic                            then_add_ff, then_add_in;
   logic [npt_pkg::ST_W-1:0]        status_ff, status_in;
   logic                            ended_ff, ended_in;

   logic [npt_pkg::DEPTH_W-1:0] depth_m1;
   logic                        counting;
   logic                        rd_issue;

   always_comb begin
      depth_m1    = depth_ff - npt_pkg::DEPTH_W'(1);
      counting    = !paused && (depth_ff != '0);
      rd_issue    = (state_ff == S_PASS) && (rd_idx_ff < depth_ff);

      state_in    = state_ff;
      depth_in    = depth_ff;
      rd_idx_in   = rd_idx_ff;
      pv_in       = pv_ff;
      wr_addr_in  = wr_addr_ff;
      sub_in      = sub_ff;
      use_old_in  = use_old_ff;
      then_add_in = then_add_ff;
      status_in   = status_ff;
      ended_in    = ended_ff;

      ctrl            = '0;
      ctrl.busy       = (state_ff != S_IDLE);
      ctrl.sub        = sub_ff;
      ctrl.use_old    = use_old_ff;
      ctrl.has_parent = (depth_ff != '0);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in   = npt_pkg::ST_OK;
               ended_in    = 1'b0;
               rd_idx_in   = '0;
               pv_in       = 1'b0;
               then_add_in = 1'b0;
               state_in    = S_DONE;
               case (operation)
                  npt_pkg::OP_ALLOC: begin
                     if (counting) begin
                        sub_in     = 1'b0;
                        use_old_in = 1'b0;
                        state_in   = S_PASS;
                     end
                  end
                  npt_pkg::OP_FREE: begin
                     if (counting) begin
                        sub_in     = 1'b1;
                        use_old_in = 1'b0;
                        state_in   = S_PASS;
                     end
                  end
                  npt_pkg::OP_REALLOC: begin
                     if (counting) begin
                        sub_in      = 1'b1;
                        use_old_in  = 1'b1;
                        then_add_in = 1'b1;
                        state_in    = S_PASS;
                     end
                  end
                  npt_pkg::OP_BEGIN: begin
                     if (depth_ff >= npt_pkg::DEPTH_W'(npt_pkg::STACK_DEPTH)) begin
                        status_in = npt_pkg::ST_OVERFLOW;
                     end else if (depth_ff != '0) begin
                        state_in = S_BEGIN_RD;
                     end else begin
                        state_in = S_BEGIN_WR;
                     end
                  end
                  npt_pkg::OP_END: begin
                     if (depth_ff == '0) begin
                        status_in = npt_pkg::ST_UNDERFLOW;
                     end else begin
                        state_in = S_END_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_PASS: begin
            // Read one level per cycle; its update is written back the cycle after.
            ctrl.cnt_rd_en = rd_issue;
            ctrl.rd_addr   = rd_idx_ff[npt_pkg::ADDR_W-1:0];
            ctrl.cnt_wr_en = pv_ff;
            ctrl.wr_addr   = wr_addr_ff;
            pv_in          = rd_issue;
            if (rd_issue) begin
               rd_idx_in  = rd_idx_ff + npt_pkg::DEPTH_W'(1);
               wr_addr_in = rd_idx_ff[npt_pkg::ADDR_W-1:0];
            end
            if (!rd_issue && pv_ff) begin
               if (then_add_ff) begin
                  sub_in      = 1'b0;
                  use_old_in  = 1'b0;
                  then_add_in = 1'b0;
                  rd_idx_in   = '0;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_BEGIN_RD: begin
            ctrl.cnt_rd_en = 1'b1;
            ctrl.rd_addr   = depth_m1[npt_pkg::ADDR_W-1:0];
            state_in       = S_BEGIN_WR;
         end
         S_BEGIN_WR: begin
            ctrl.cnt_wr_en = 1'b1;
            ctrl.frm_wr_en = 1'b1;
            ctrl.wr_clear  = 1'b1;
            ctrl.wr_addr   = depth_ff[npt_pkg::ADDR_W-1:0];
            depth_in       = depth_ff + npt_pkg::DEPTH_W'(1);
            state_in       = S_DONE;
         end
         S_END_RD: begin
            ctrl.cnt_rd_en = 1'b1;
            ctrl.frm_rd_en = 1'b1;
            ctrl.rd_addr   = depth_m1[npt_pkg::ADDR_W-1:0];
            depth_in       = depth_m1;
            ended_in       = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            ctrl.rsp_load = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      stat.status = status_ff;
      stat.ended  = ended_ff;
      stat.depth  = depth_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         depth_ff    <= '0;
         rd_idx_ff   <= '0;
         pv_ff       <= 1'b0;
         wr_addr_ff  <= '0;
         sub_ff      <= 1'b0;
         use_old_ff  <= 1'b0;
         then_add_ff <= 1'b0;
         status_ff   <= npt_pkg::ST_OK;
         ended_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         depth_ff    <= depth_in;
         rd_idx_ff   <= rd_idx_in;
         pv_ff       <= pv_in;
         wr_addr_ff  <= wr_addr_in;
         sub_ff      <= sub_in;
         use_old_ff  <= use_old_in;
         then_add_ff <= then_add_in;
         status_ff   <= status_in;
         ended_ff    <= ended_in;
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= npt_pkg::DEPTH_W'(npt_pkg::STACK_DEPTH))
      else $error("phase stack depth beyond its capacity");

   a_rw_distinct: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cnt_wr_en && ctrl.cnt_rd_en) |-> (ctrl.wr_addr != ctrl.rd_addr))
      else $error("counter memory read and written at the same level");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && accept) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after taking a transaction");

endmodule

`default_nettype wire

/* hw/rtl/nested_phase_memory_peak_tracker.sv */
// Top level of the nested phase memory peak tracker: ports, memories and result register.
// Depends on npt_pkg, npt_ram, npt_alu and npt_seq.
//
//   Channel  Prefix  Direction  Handshake      Payload
//   request  req_    in         valid / stall  npt_req_type (operation, amounts, timestamp)
//   result   rsp_    out        valid / stall  npt_rsp_type (status, depth, phase record)
//   control  csr_    in         valid / ready  counting_paused bit
//
// An allocate or free that finds a phase open and counting running walks the open levels
// once, and a realloc walks them twice. A nested begin reads the parent level and then
// writes the new one; an outermost begin only writes it, an end only reads the popped
// level, and every other transaction goes straight to its result. The walk goes through
// the single counter unit and the one-read, one-write counter memory, a level at a time.
// Reset is synchronous and active high; it empties the phase stack and clears the pause bit,
// while the level memories stay undefined until a phase is begun. The request side stalls
// while a transaction is in work; a stalled result does not hold off the next request, which
// only waits at its end until the result register is free again.
`default_nettype none

module nested_phase_memory_peak_tracker (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire npt_pkg::npt_req_type  req_data,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output npt_pkg::npt_rsp_type       rsp_data,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_data
);

   // Always writable; software must change it only while idle; the block does not enforce it.
   logic paused_ff, paused_in;

   // The request is held for the whole transaction, since the amounts are reused on
   // every level and the timestamp goes into both a new frame and the end report.
   npt_pkg::npt_req_type req_ff;

   npt_pkg::npt_rsp_type rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   npt_pkg::npt_ctrl_type ctrl;
   npt_pkg::npt_stat_type stat;

   logic accept;
   logic out_free;

   npt_pkg::npt_cnt_type cnt_rd;
   npt_pkg::npt_cnt_type cnt_wr;
   npt_pkg::npt_frm_type frm_rd;
   npt_pkg::npt_frm_type frm_wr;

   logic [npt_pkg::COUNT_WIDTH-1:0] amount_value;
   logic [npt_pkg::COUNT_WIDTH-1:0] now_next;
   logic [npt_pkg::COUNT_WIDTH-1:0] peak_next;

   assign req_stall = ctrl.busy;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // The result register can take a new transaction's result when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   npt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_data.operation),
      .paused    (paused_ff),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   // A realloc first walks the levels with the released size, then with the new one.
   always_comb begin
      if (ctrl.use_old) begin
         amount_value = npt_pkg::COUNT_WIDTH'(req_ff.old_amount);
      end else begin
         amount_value = npt_pkg::COUNT_WIDTH'(req_ff.amount);
      end
   end

   npt_alu u_alu (
      .now_value    (cnt_rd.now),
      .peak_value   (cnt_rd.peak),
      .amount_value (amount_value),
      .subtract     (ctrl.sub),
      .now_next     (now_next),
      .peak_next    (peak_next)
   );

   // A new phase starts with zero usage and peak; otherwise the updated level goes back.
   always_comb begin
      if (ctrl.wr_clear) begin
         cnt_wr = '0;
      end else begin
         cnt_wr.now  = now_next;
         cnt_wr.peak = peak_next;
      end
      // The parent's usage was read just before a nested begin; the outermost gets zero.
      if (ctrl.has_parent) begin
         frm_wr.offset = cnt_rd.now;
      end else begin
         frm_wr.offset = '0;
      end
      frm_wr.start_time = req_ff.timestamp;
   end

   npt_ram #(
      .WIDTH (npt_pkg::CNT_W),
      .DEPTH (npt_pkg::STACK_DEPTH)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (ctrl.cnt_wr_en),
      .wr_addr (ctrl.wr_addr),
      .wr_data (cnt_wr),
      .rd_en   (ctrl.cnt_rd_en),
      .rd_addr (ctrl.rd_addr),
      .rd_data (cnt_rd)
   );

   npt_ram #(
      .WIDTH (npt_pkg::FRM_W),
      .DEPTH (npt_pkg::STACK_DEPTH)
   ) u_frm_ram (
      .clock   (clock),
      .wr_en   (ctrl.frm_wr_en),
      .wr_addr (ctrl.wr_addr),
      .wr_data (frm_wr),
      .rd_en   (ctrl.frm_rd_en),
      .rd_addr (ctrl.rd_addr),
      .rd_data (frm_rd)
   );

   // The popped level's read data stays in the memory output registers until the result
   // is loaded, because no other read is issued in between.
   always_comb begin
      paused_in = paused_ff;
      if (csr_valid) begin
         paused_in = csr_data;
      end

      rsp_data_in             = rsp_data_ff;
      if (ctrl.rsp_load) begin
         rsp_data_in.status      = stat.status;
         rsp_data_in.phase_ended = stat.ended;
         rsp_data_in.open_phases = npt_pkg::OPEN_W'(stat.depth);
         if (stat.ended) begin
            rsp_data_in.phase_offset  = npt_pkg::FIELD_W'(frm_rd.offset);
            rsp_data_in.phase_peak    = npt_pkg::FIELD_W'(cnt_rd.peak);
            rsp_data_in.phase_current = npt_pkg::FIELD_W'(cnt_rd.now);
            rsp_data_in.phase_start   = frm_rd.start_time;
            rsp_data_in.phase_end     = req_ff.timestamp;
         end else begin
            rsp_data_in.phase_offset  = '0;
            rsp_data_in.phase_peak    = '0;
            rsp_data_in.phase_current = '0;
            rsp_data_in.phase_start   = '0;
            rsp_data_in.phase_end     = '0;
         end
      end

      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paused_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         paused_ff    <= paused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while a result still waits");

   a_ended_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.phase_ended) |-> (rsp_data.status == npt_pkg::ST_OK))
      else $error("popped phase reported together with an error status");

endmodule

`default_nettype wire

/* verif/nested_phase_memory_peak_tracker_test.sv */
// Self-checking testbench for the nested phase memory peak tracker.
// Needs only npt_pkg and the RTL of nested_phase_memory_peak_tracker.
`timescale 1ns / 100ps

module nested_phase_memory_peak_tracker_test;

   // Run bounds. Worst case per transaction is a realloc over sixteen levels
   // plus an idle gap and a result stall; for just over 1000 transactions the
   // cycle limit leaves a wide margin.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 150;

   // Operation codes that the block does not define; it must ignore them.
   localparam logic [npt_pkg::OP_W-1:0]  OP_SPARE_LO = 3'd5;
   localparam logic [npt_pkg::OP_W-1:0]  OP_SPARE_HI = 3'd7;
   localparam logic [npt_pkg::AMT_W-1:0] AMT_MAX     = '1;
   localparam logic [npt_pkg::TS_W-1:0]  TS_MAX      = '1;

   typedef enum int {MIX_BALANCED, MIX_DEEP, MIX_SHALLOW} mix_kind_type;

   // Every input of the block starts at a known value; reset is high from time zero.
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   npt_pkg::npt_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   npt_pkg::npt_rsp_type rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_data  = 1'b0;

   nested_phase_memory_peak_tracker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // Events waiting to be offered, and the phase reports expected back, oldest first.
   npt_pkg::npt_req_type pending_events[$];
   npt_pkg::npt_rsp_type expected_reports[$];

   // Shadow copy of the phase stack and of the pause bit. Only levels below
   // open_count are ever read, and each one is written when its phase begins.
   logic [npt_pkg::COUNT_WIDTH-1:0] lvl_now    [npt_pkg::STACK_DEPTH];
   logic [npt_pkg::COUNT_WIDTH-1:0] lvl_peak   [npt_pkg::STACK_DEPTH];
   logic [npt_pkg::COUNT_WIDTH-1:0] lvl_offset [npt_pkg::STACK_DEPTH];
   logic [npt_pkg::TS_W-1:0]        lvl_start  [npt_pkg::STACK_DEPTH];
   int                              open_count = 0;
   logic                            pause_bit  = 1'b0;

   // Stimulus controls shared with the driver and the monitor. The long hold-off
   // is requested by bumping hold_asked; the monitor counts it out on its own.
   logic idling_on  = 1'b1;
   int   hold_asked = 0;

   // Statistics for the closing summary.
   int fail_count      = 0;
   int reports_checked = 0;
   int phases_reported = 0;
   int overflow_count  = 0;
   int underflow_count = 0;
   int ignored_count   = 0;
   int deepest         = 0;
   int paused_events   = 0;
   int cycle_count     = 0;

   // Allocation side of an event: every open level grows, and its peak follows
   // when the new usage is above it (unsigned, after the 48 bit wrap).
   function automatic void grow_levels(input logic [npt_pkg::AMT_W-1:0] amt);
      for (int i = 0; i < open_count; i++) begin
         lvl_now[i] = lvl_now[i] + npt_pkg::COUNT_WIDTH'(amt);
         if (lvl_now[i] > lvl_peak[i])
            lvl_peak[i] = lvl_now[i];
      end
   endfunction

   // Release side of an event: every open level shrinks, wrapping below zero.
   function automatic void shrink_levels(input logic [npt_pkg::AMT_W-1:0] amt);
      for (int i = 0; i < open_count; i++)
         lvl_now[i] = lvl_now[i] - npt_pkg::COUNT_WIDTH'(amt);
   endfunction

   // Applies one event to the shadow stack and returns the report the block
   // must give for it. Every event, even an ignored one, gives exactly one.
   function automatic npt_pkg::npt_rsp_type track_event(input npt_pkg::npt_req_type ev);
      npt_pkg::npt_rsp_type rep;
      logic                 counting;
      rep        = '0;
      rep.status = npt_pkg::ST_OK;
      counting   = !pause_bit && (open_count > 0);
      if (pause_bit && (ev.operation inside {npt_pkg::OP_ALLOC, npt_pkg::OP_FREE,
                                             npt_pkg::OP_REALLOC}))
         paused_events++;
      case (ev.operation)
         npt_pkg::OP_ALLOC: begin
            if (counting)
               grow_levels(ev.amount);
         end
         npt_pkg::OP_FREE: begin
            if (counting)
               shrink_levels(ev.amount);
         end
         npt_pkg::OP_REALLOC: begin
            // The old block is released before the new one is counted, so the
            // peak only sees the usage after both halves.
            if (counting) begin
               shrink_levels(ev.old_amount);
               grow_levels(ev.amount);
            end
         end
         npt_pkg::OP_BEGIN: begin
            if (open_count >= npt_pkg::STACK_DEPTH) begin
               rep.status = npt_pkg::ST_OVERFLOW;
               overflow_count++;
            end else begin
               // The outermost phase has no parent, so its offset is zero.
               lvl_offset[open_count] = (open_count > 0) ? lvl_now[open_count - 1] : '0;
               lvl_peak[open_count]   = '0;
               lvl_now[open_count]    = '0;
               lvl_start[open_count]  = ev.timestamp;
               open_count++;
               if (open_count > deepest)
                  deepest = open_count;
            end
         end
         npt_pkg::OP_END: begin
            if (open_count == 0) begin
               rep.status = npt_pkg::ST_UNDERFLOW;
               underflow_count++;
            end else begin
               open_count--;
               rep.phase_ended   = 1'b1;
               rep.phase_offset  = npt_pkg::FIELD_W'(lvl_offset[open_count]);
               rep.phase_peak    = npt_pkg::FIELD_W'(lvl_peak[open_count]);
               rep.phase_current = npt_pkg::FIELD_W'(lvl_now[open_count]);
               rep.phase_start   = lvl_start[open_count];
               rep.phase_end     = ev.timestamp;
               phases_reported++;
            end
         end
         default: begin
            ignored_count++;
         end
      endcase
      rep.open_phases = npt_pkg::OPEN_W'(open_count);
      return rep;
   endfunction

   function automatic npt_pkg::npt_req_type make_event(input logic [npt_pkg::OP_W-1:0] op,
                                                       input logic [npt_pkg::AMT_W-1:0] amt,
                                                       input logic [npt_pkg::AMT_W-1:0] old_amt,
                                                       input logic [npt_pkg::TS_W-1:0] ts);
      npt_pkg::npt_req_type ev;
      ev.operation  = op;
      ev.amount     = amt;
      ev.old_amount = old_amt;
      ev.timestamp  = ts;
      return ev;
   endfunction

   // Amounts lean toward zero, the maximum and small values so that peaks move
   // in both small and large steps; the rest are fully random.
   function automatic logic [npt_pkg::AMT_W-1:0] random_amount();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return AMT_MAX;
         2, 3, 4: return npt_pkg::AMT_W'($urandom_range(0, 255));
         default: return $urandom();
      endcase
   endfunction

   // The mix sets how often phases are opened and closed: deep runs into the
   // full stack, shallow into ends with nothing open.
   function automatic npt_pkg::npt_req_type random_event(input mix_kind_type mix);
      int                        begin_pct;
      int                        end_pct;
      int                        roll;
      logic [npt_pkg::OP_W-1:0]  op;
      logic [npt_pkg::TS_W-1:0]  ts;
      case (mix)
         MIX_DEEP:    begin begin_pct = 40; end_pct = 10; end
         MIX_SHALLOW: begin begin_pct = 12; end_pct = 30; end
         default:     begin begin_pct = 15; end_pct = 14; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < begin_pct)
         op = npt_pkg::OP_BEGIN;
      else if (roll < begin_pct + end_pct)
         op = npt_pkg::OP_END;
      else if (roll < begin_pct + end_pct + 4)
         op = npt_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else begin
         case ($urandom_range(0, 5))
            0, 1, 2: op = npt_pkg::OP_ALLOC;
            3, 4:    op = npt_pkg::OP_FREE;
            default: op = npt_pkg::OP_REALLOC;
         endcase
      end
      case ($urandom_range(0, 15))
         0:       ts = '0;
         1:       ts = TS_MAX;
         default: ts = $urandom();
      endcase
      return make_event(op, random_amount(), random_amount(), ts);
   endfunction

   // Driver. A transaction is taken at an edge where valid is high and stall is
   // low; until then the payload is held. After each accepted transaction it
   // draws a random idle gap when idling is on. The prediction is made here, at
   // the very edge of acceptance, from the payload that was taken.
   always @(posedge clock) begin : drive_requests
      npt_pkg::npt_req_type next_item;
      logic                 next_valid;
      int                   gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         next_item  = req_data;
         if (req_valid && !req_stall) begin
            expected_reports.push_back(track_event(req_data));
            next_valid = 1'b0;
            gap_left   = idling_on ? $urandom_range(0, 4) : 0;
         end
         if (!next_valid) begin
            if (gap_left > 0)
               gap_left--;
            else if (pending_events.size() > 0) begin
               next_item  = pending_events.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
         req_data  <= next_item;
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Monitor. Each accepted result is compared field by field with the oldest
   // expected report. After each one the receiver may stall at random when
   // idling is on, and on request it holds off for a long stretch so that the
   // result register stays full and the block has to stall its request side.
   always @(posedge clock) begin : check_reports
      npt_pkg::npt_rsp_type want;
      int                   stall_left;
      int                   hold_left;
      int                   hold_seen;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_seen  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t ns: result with no transaction outstanding, expected none, actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("phase_ended", 64'(want.phase_ended), 64'(rsp_data.phase_ended));
               check_field("open_phases", 64'(want.open_phases), 64'(rsp_data.open_phases));
               check_field("phase_offset", 64'(want.phase_offset),
                           64'(rsp_data.phase_offset));
               check_field("phase_peak", 64'(want.phase_peak), 64'(rsp_data.phase_peak));
               check_field("phase_current", 64'(want.phase_current),
                           64'(rsp_data.phase_current));
               check_field("phase_start", 64'(want.phase_start), 64'(rsp_data.phase_start));
               check_field("phase_end", 64'(want.phase_end), 64'(rsp_data.phase_end));
               reports_checked++;
            end
            stall_left = idling_on ? $urandom_range(0, 4) : 0;
         end else if (stall_left > 0)
            stall_left--;
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
         end else if (hold_left > 0)
            hold_left--;
         rsp_stall <= (stall_left > 0) || (hold_left > 0);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d events pending and %0d results outstanding",
                  $time, pending_events.size(), expected_reports.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Writes the pause bit. Only called while the block is idle, so the shadow
   // copy can follow at once.
   task automatic write_pause(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      pause_bit = value;
   endtask

   // Waits until every queued event has been taken and every report has come
   // back, then lets the block settle before anything else is changed.
   task automatic drain();
      do
         @(negedge clock);
      while (pending_events.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase of the run: set the pause bit, queue the events, and
   // wait until all of them are answered. The sender thus pauses between phases.
   task automatic run_phase(input logic pause_value, input int count, input mix_kind_type mix,
                            input logic idle_value, input logic long_hold);
      write_pause(pause_value);
      idling_on = idle_value;
      if (long_hold)
         hold_asked++;
      repeat (count) pending_events.push_back(random_event(mix));
      drain();
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: ends and counting with nothing open, the outermost and
      // a nested begin, zero and full-scale amounts, a free that wraps the
      // counter below zero, both realloc extremes, and unused op codes 5 and 7.
      write_pause(1'b0);
      pending_events.push_back(make_event(npt_pkg::OP_END,     '0,       '0,      32'd5));
      pending_events.push_back(make_event(npt_pkg::OP_ALLOC,   32'd100,  '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_FREE,    32'd7,    '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_BEGIN,   '0,       '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_ALLOC,   AMT_MAX,  '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_ALLOC,   '0,       '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_FREE,    '0,       '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_REALLOC, '0,       AMT_MAX, '0));
      pending_events.push_back(make_event(npt_pkg::OP_BEGIN,   '0,       '0,      TS_MAX));
      pending_events.push_back(make_event(npt_pkg::OP_ALLOC,   32'd1234, '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_FREE,    AMT_MAX,  '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_REALLOC, AMT_MAX,  '0,      '0));
      pending_events.push_back(make_event(OP_SPARE_LO,         AMT_MAX,  AMT_MAX, TS_MAX));
      pending_events.push_back(make_event(OP_SPARE_HI,         AMT_MAX,  AMT_MAX, TS_MAX));
      pending_events.push_back(make_event(npt_pkg::OP_END,     AMT_MAX,  AMT_MAX, TS_MAX));
      pending_events.push_back(make_event(npt_pkg::OP_END,     '0,       '0,      '0));
      pending_events.push_back(make_event(npt_pkg::OP_END,     '0,       '0,      TS_MAX));
      drain();

      // Random part. The first phase carries the long receiver hold-off, the
      // deep phase runs without any idling so the stack overflows back to back,
      // and two phases run with counting paused.
      run_phase(1'b0, 300, MIX_BALANCED, 1'b1, 1'b1);
      run_phase(1'b1, 120, MIX_BALANCED, 1'b1, 1'b0);
      run_phase(1'b0, 250, MIX_DEEP,     1'b0, 1'b0);
      run_phase(1'b1,  80, MIX_SHALLOW,  1'b1, 1'b0);
      run_phase(1'b0, 250, MIX_SHALLOW,  1'b1, 1'b0);

      $display("Checked %0d results: %0d phases reported, %0d overflows, %0d underflows.",
               reports_checked, phases_reported, overflow_count, underflow_count);
      $display("Deepest nesting %0d, %0d ignored op codes, %0d counting events while paused.",
               deepest, ignored_count, paused_events);
      if (fail_count == 0 && expected_reports.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/npt_pkg.sv
hw/rtl/npt_ram.sv
hw/rtl/npt_alu.sv
hw/rtl/npt_seq.sv
hw/rtl/nested_phase_memory_peak_tracker.sv
verif/nested_phase_memory_peak_tracker_test.sv
